FILE: rtl/era_pkg.sv
// ----------------------------------------------------------------------------
// era_pkg - shared constants for the earth rotation angle core
// Fixed-point constants of the integer ERA formula and the divider widths.
// ----------------------------------------------------------------------------
`default_nettype none

package era_pkg;

  localparam int ANGLE_BITS_DEF = 48;
  localparam int ROT_W          = 18;
  localparam int ANGLE_OUT_W    = 48;
  localparam int SEC_W          = 34;
  localparam int NSEC_W         = 30;
  localparam int OFS_W          = 31;

  // Remainder width of the divider chain and width of the numerator sum.
  localparam int RW = 121;
  localparam int NW = 124;

  localparam logic [127:0] ERA_A    = 128'd77905727326400000;
  localparam logic [127:0] ERA_B    = 128'd100273781191135448;
  localparam logic [127:0] DAY_NS   = 128'd86400000000000;
  localparam logic [127:0] E17      = 128'd100000000000000000;
  localparam logic [127:0] GIGA_NS  = 128'd1000000000;
  localparam logic [127:0] DENOM    = E17 * DAY_NS;
  // Divisor aligned to the rotation MSB; rotations are biased by 2^17 turns.
  localparam logic [127:0] DSH      = DENOM << (ROT_W - 1);
  localparam logic [127:0] DSH2     = DSH << 1;
  localparam logic [127:0] K0       = ERA_A * DAY_NS + DSH;
  localparam logic [127:0] C_SEC    = ERA_B * GIGA_NS;
  localparam logic signed [35:0] UNIX_AT_EPOCH = 36'sd946728000;

endpackage

`default_nettype wire

FILE: rtl/earth_rotation_angle_from_time_core.sv
// ----------------------------------------------------------------------------
// earth_rotation_angle_from_time_core - UNIX time to Earth rotation angle
// Whole rotations since UT1 J2000 and the angle as a binary fraction of a turn.
// ----------------------------------------------------------------------------
//
//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_stall  unix_seconds, unix_nanoseconds
//  out_*        output     out_valid/out_stall rotations, angle_fraction
//  cfg_*        input      cfg_wr_en          ut1_offset_ns
//
//  One transfer per clock unless out_stall holds the chain. Four
//  numerator stages (rebase, partial products, two adds), then one divider
//  cell per quotient bit. The last cell is the output register.
//  Reset (sync, active low) clears the valid bits and the UT1 offset.
//  out_stall with out_valid freezes the whole chain; in_stall is high only then.
//
`default_nettype none

module earth_rotation_angle_from_time_core
  import era_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
)(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [SEC_W-1:0] in_unix_seconds,
  input  wire logic [NSEC_W-1:0]       in_unix_nanoseconds,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [ROT_W-1:0]      out_rotations,
  output logic [ANGLE_OUT_W-1:0]       out_angle_fraction,
  input  wire logic                    cfg_wr_en,
  input  wire logic signed [OFS_W-1:0] cfg_ut1_offset_ns
);

  localparam int QW = ROT_W + ANGLE_BITS;

  logic                    adv;
  logic signed [OFS_W-1:0] ofs_r;
  logic                    front_vld;
  logic [RW-1:0]           front_num;
  logic                    vld  [0:QW];
  logic [RW-1:0]           rem  [0:QW];
  logic [QW-1:0]           quo  [0:QW];
  logic [ANGLE_BITS-1:0]   frac;

  // Chain moves whenever the output register is free or being drained.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r <= '0;
    end else if (cfg_wr_en) begin
      ofs_r <= cfg_ut1_offset_ns;
    end
  end

  era_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .vld_i  (in_valid),
    .sec_i  (in_unix_seconds),
    .nsec_i (in_unix_nanoseconds),
    .ofs_i  (ofs_r),
    .vld_o  (front_vld),
    .num_o  (front_num)
  );

  assign vld[0] = front_vld;
  assign rem[0] = front_num;
  assign quo[0] = '0;

  // One cell per quotient bit, rotation MSB first.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    era_div_cell #(.QW(QW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (vld[i]),
      .rem_i (rem[i]),
      .q_i   (quo[i]),
      .vld_o (vld[i+1]),
      .rem_o (rem[i+1]),
      .q_o   (quo[i+1])
    );
  end

  // Undo the 2^17-turn bias by flipping the rotation sign bit.
  assign frac               = quo[QW][ANGLE_BITS-1:0];
  assign out_valid          = vld[QW];
  assign out_rotations      = $signed({~quo[QW][QW-1], quo[QW][QW-2 -: ROT_W-1]});
  assign out_angle_fraction = ANGLE_OUT_W'(frac);

  a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
    front_vld |-> (front_num < DSH2[RW-1:0]))
    else $error("biased numerator out of divider range");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (rem[QW] < DSH2[RW-1:0]))
    else $error("divider remainder out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(front_vld) && $stable(vld[1])))
    else $error("chain moved while output stalled");

endmodule

`default_nettype wire

FILE: rtl/era_front.sv
// ----------------------------------------------------------------------------
// era_front - biased numerator pipeline
// Rebases the time to UT1 J2000 and forms A*day + B*t + 2^17*D in four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module era_front
  import era_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    adv,
  input  wire logic                    vld_i,
  input  wire logic [SEC_W-1:0]        sec_i,
  input  wire logic [NSEC_W-1:0]       nsec_i,
  input  wire logic signed [OFS_W-1:0] ofs_i,
  output logic                         vld_o,
  output logic [RW-1:0]                num_o
);

  logic [3:0]              vld_r;
  logic signed [34:0]      s_r, s_nxt;
  logic signed [34:0]      u_r, u_nxt;
  logic signed [64:0]      pp_r [0:4];
  logic signed [64:0]      pp_nxt [0:4];
  logic signed [NW-1:0]    a_r, a_nxt, b_r, b_nxt, n_r, n_nxt;

  always_comb begin
    s_nxt = 35'($signed({{2{sec_i[SEC_W-1]}}, sec_i}) - UNIX_AT_EPOCH);
    u_nxt = $signed({5'd0, nsec_i}) + 35'(ofs_i);
    pp_nxt[0] = $signed({1'b0, C_SEC[28:0]})  * s_r;
    pp_nxt[1] = $signed({1'b0, C_SEC[57:29]}) * s_r;
    pp_nxt[2] = $signed({1'b0, C_SEC[86:58]}) * s_r;
    pp_nxt[3] = $signed({1'b0, ERA_B[28:0]})  * u_r;
    pp_nxt[4] = $signed({1'b0, ERA_B[57:29]}) * u_r;
    a_nxt = $signed(K0[NW-1:0]) + NW'(pp_r[0]) + (NW'(pp_r[1]) <<< 29);
    b_nxt = (NW'(pp_r[2]) <<< 58) + NW'(pp_r[3]) + (NW'(pp_r[4]) <<< 29);
    n_nxt = a_r + b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_r <= s_nxt;
      u_r <= u_nxt;
      for (int i = 0; i < 5; i++) begin
        pp_r[i] <= pp_nxt[i];
      end
      a_r <= a_nxt;
      b_r <= b_nxt;
      n_r <= n_nxt;
    end
  end

  assign vld_o = vld_r[3];
  assign num_o = n_r[RW-1:0];

endmodule

`default_nettype wire

FILE: rtl/era_div_cell.sv
// ----------------------------------------------------------------------------
// era_div_cell - one restoring-division cell
// Compares the partial remainder with the aligned divisor, emits one bit.
// ----------------------------------------------------------------------------
`default_nettype none

module era_div_cell
  import era_pkg::*;
#(
  parameter int QW = ROT_W + ANGLE_BITS_DEF
)(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          vld_i,
  input  wire logic [RW-1:0] rem_i,
  input  wire logic [QW-1:0] q_i,
  output logic               vld_o,
  output logic [RW-1:0]      rem_o,
  output logic [QW-1:0]      q_o
);

  logic          vld_r;
  logic [RW-1:0] rem_r, rem_nxt, diff;
  logic [QW-1:0] q_r, q_nxt;
  logic          ge;

  always_comb begin
    ge      = rem_i >= DSH[RW-1:0];
    diff    = ge ? (rem_i - DSH[RW-1:0]) : rem_i;
    rem_nxt = {diff[RW-2:0], 1'b0};
    q_nxt   = {q_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;

endmodule

`default_nettype wire

FILE: verif/earth_rotation_angle_from_time_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// earth_rotation_angle_from_time_core_tb - self-checking bench for the ERA core
// Drives timestamps through the core and checks rotations and angle fraction
// against an exact 128-bit integer predictor, across several UT1 offsets.
// ----------------------------------------------------------------------------
`default_nettype none

class era_scoreboard;
  typedef struct packed {
    logic signed [17:0] rot;
    logic [47:0]        frac;
  } era_result_t;

  era_result_t pending_q[$];
  int          errors;
  logic signed [30:0] ut1_ofs;

  function new();
    errors  = 0;
    ut1_ofs = '0;
  endfunction

  // Exact ERA: N = A*day + B*t, floor divide by 1e17*day, then fraction bits.
  function era_result_t compute_era(logic signed [33:0] secs, logic [29:0] nsec);
    logic signed [127:0] t_ns;
    logic signed [127:0] num;
    logic [127:0]        denom;
    logic [127:0]        mag;
    logic [127:0]        quot;
    logic [127:0]        rem;
    logic [47:0]         fr;
    era_result_t         res;
    denom = 128'd100000000000000000 * 128'd86400000000000;
    t_ns  = (128'(secs) - 128'sd946728000) * 128'sd1000000000
            + 128'($unsigned(nsec)) + 128'(ut1_ofs);
    num   = 128'd77905727326400000 * 128'd86400000000000
            + 128'd100273781191135448 * t_ns;
    if (num < 0) begin
      mag  = -num;
      quot = mag / denom;
      rem  = mag % denom;
      if (rem != 0) begin
        quot = quot + 1;
        rem  = denom - rem;
      end
      quot = -quot;
    end else begin
      quot = num / denom;
      rem  = num % denom;
    end
    fr = '0;
    for (int i = 0; i < 48; i++) begin
      rem = rem << 1;
      fr  = fr << 1;
      if (rem >= denom) begin
        rem   = rem - denom;
        fr[0] = 1'b1;
      end
    end
    res.rot  = quot[17:0];
    res.frac = fr;
    return res;
  endfunction

  function void note_timestamp(logic signed [33:0] secs, logic [29:0] nsec);
    pending_q.push_back(compute_era(secs, nsec));
  endfunction

  function void check_angle(logic signed [17:0] rot, logic [47:0] frac);
    era_result_t exp_r;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result rot=%0d frac=%h", $time, rot, frac);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (exp_r.rot !== rot) begin
      $display("%0t: rotations mismatch exp=%0d act=%0d", $time, exp_r.rot, rot);
      errors++;
    end
    if (exp_r.frac !== frac) begin
      $display("%0t: angle_fraction mismatch exp=%h act=%h", $time, exp_r.frac, frac);
      errors++;
    end
  endfunction
endclass

module earth_rotation_angle_from_time_core_tb;
  import era_pkg::*;

  localparam int LATENCY = 4 + 18 + 48;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SEC_W-1:0] in_unix_seconds;
  logic [NSEC_W-1:0]       in_unix_nanoseconds;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [ROT_W-1:0] out_rotations;
  logic [ANGLE_OUT_W-1:0]  out_angle_fraction;
  logic                    cfg_wr_en;
  logic signed [OFS_W-1:0] cfg_ut1_offset_ns;

  era_scoreboard sb;
  int send_idle_pct;   // sender gap chance per cycle
  int recv_idle_pct;   // receiver stall chance per cycle
  int hold_cycles;     // long receiver hold-off, counted in the receiver loop

  earth_rotation_angle_from_time_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_unix_seconds     (in_unix_seconds),
    .in_unix_nanoseconds (in_unix_nanoseconds),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_rotations       (out_rotations),
    .out_angle_fraction  (out_angle_fraction),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_ut1_offset_ns   (cfg_ut1_offset_ns)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: sample at the rising edge, change stall at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_angle(out_rotations, out_angle_fraction);
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall   <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one timestamp; optional gap first; holds until transferred.
  task automatic send_timestamp(logic signed [33:0] secs, logic [29:0] nsec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid            <= 1'b1;
    in_unix_seconds     <= secs;
    in_unix_nanoseconds <= nsec;
    do @(posedge clk); while (in_stall);
    sb.note_timestamp(secs, nsec);
    @(negedge clk);
  endtask

  // Idle until every expected result is out, then let the pipe settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Offset changes only while the core is empty.
  task automatic write_ut1_offset(logic signed [30:0] ofs);
    cfg_wr_en         <= 1'b1;
    cfg_ut1_offset_ns <= ofs;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.ut1_ofs = ofs;
  endtask

  // Random timestamp: half near J2000, the rest any 32-bit or 34-bit pattern.
  task automatic send_random(int n);
    logic signed [33:0] s;
    logic [29:0]        ns;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0:       s = 34'($urandom);
        1:       s = 34'({$urandom, $urandom}); // any 34-bit pattern
        default: s = 34'sd946728000 + 34'($signed($urandom_range(200000000)) - 100000000);
      endcase
      // nanoseconds above 1e9 are legal and added without carry
      ns = ($urandom_range(7) == 0) ? 30'($urandom) : 30'($urandom_range(999999999));
      send_timestamp(s, ns);
    end
  endtask

  initial begin
    logic signed [33:0] dir_secs [8];
    logic [29:0]        dir_nsec [4];
    sb = new();
    send_idle_pct       = 0;
    recv_idle_pct       = 0;
    hold_cycles         = 0;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_unix_seconds     = '0;
    in_unix_nanoseconds = '0;
    cfg_wr_en           = 1'b0;
    cfg_ut1_offset_ns   = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, epoch instant, unnormalized nanoseconds.
    dir_secs = '{34'sh1FFFFFFFF, -34'sh200000000, 34'sd0, -34'sd1,
                 34'sd946728000, 34'sd946727999, 34'sd8000000000, -34'sd8000000000};
    dir_nsec = '{30'd0, 30'd999999999, 30'h3FFFFFFF, 30'd500000000};
    foreach (dir_secs[i])
      send_timestamp(dir_secs[i], dir_nsec[i % 4]);
    send_timestamp(34'sd946728000, 30'd0);
    send_timestamp(34'sd946727999, 30'h3FFFFFFF);
    drain_results();

    // Offset extremes on the same edge cases.
    write_ut1_offset(31'sh3FFFFFFF);
    foreach (dir_secs[i]) send_timestamp(dir_secs[i], dir_nsec[(i + 1) % 4]);
    drain_results();
    write_ut1_offset(-31'sh40000000);
    foreach (dir_secs[i]) send_timestamp(dir_secs[i], dir_nsec[(i + 2) % 4]);
    drain_results();

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    write_ut1_offset(31'sd816000000);
    send_idle_pct = 23; recv_idle_pct = 48;
    send_random(260);
    drain_results(); // sender pauses until all results are back

    write_ut1_offset(-31'sd184000000);
    send_idle_pct = 48; recv_idle_pct = 23;
    send_random(260);
    drain_results();

    write_ut1_offset(31'($urandom));
    send_idle_pct = 0; recv_idle_pct = 0;
    hold_cycles = 3 * LATENCY;  // long back-pressure: pipe fills, input stalls
    send_random(280);
    drain_results();
    if (sb.errors == 0)
      $display("** earth_rotation_angle_from_time_core: PASSED **");
    else
      $display("** earth_rotation_angle_from_time_core: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** earth_rotation_angle_from_time_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
